### design/ntp_pkg.sv
// Shared types, character codes and the frequency table of the note track text parser.
`timescale 1ns / 1ps
`default_nettype none

package ntp_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

    // Token phase codes
    localparam logic [2:0] PH_EMPTY     = 3'd0;
    localparam logic [2:0] PH_LETTER    = 3'd1;
    localparam logic [2:0] PH_SHARP     = 3'd2;
    localparam logic [2:0] PH_DIGIT     = 3'd3;
    localparam logic [2:0] PH_WAVE      = 3'd4;
    localparam logic [2:0] PH_DECAY     = 3'd5;
    localparam logic [2:0] PH_LONE_DASH = 3'd6;
    localparam logic [2:0] PH_JUNK      = 3'd7;

    // Result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    // Waveform codes
    localparam logic [1:0] WAVE_SINE = 2'd0;
    localparam logic [1:0] WAVE_PULSE = 2'd1;
    localparam logic [1:0] WAVE_SAW  = 2'd2;
    localparam logic [1:0] WAVE_TRI  = 2'd3;

    localparam logic [1:0] END_MATCHED = 2'd3;

    // Character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_D     = 8'h44;

    typedef struct packed {
        logic [3:0] octave;
        logic [3:0] offset;
        logic       sharp;
    } note_key_t;

    typedef struct packed {
        logic [6:0]  note_number;
        logic [21:0] frequency_q8;
    } note_freq_t;

    typedef struct packed {
        logic [3:0]  channel;
        logic        is_rest;
        logic        has_decay;
        logic [1:0]  waveform;
        logic [6:0]  note_number;
        logic [21:0] frequency_q8;
        logic [1:0]  status;
        logic        line_end;
        logic        end_of_track;
    } result_t;

    // Octave-0 frequencies of C..B scaled by 2^24.
    function automatic logic [29:0] freq_base(input logic [3:0] k);
        logic [29:0] v;
        begin
            case (k)
                4'd0:    v = 30'd274334289;
                4'd1:    v = 30'd290647054;
                4'd2:    v = 30'd307929828;
                4'd3:    v = 30'd326240288;
                4'd4:    v = 30'd345639545;
                4'd5:    v = 30'd366192342;
                4'd6:    v = 30'd387967272;
                4'd7:    v = 30'd411037006;
                4'd8:    v = 30'd435478539;
                4'd9:    v = 30'd461373440;
                4'd10:   v = 30'd488808132;
                4'd11:   v = 30'd517874176;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

    // Bit 4 flags a note letter, bits 3:0 hold its semitone offset.
    function automatic logic [4:0] letter_code(input logic [7:0] c);
        logic [4:0] v;
        begin
            case (c)
                8'h43:   v = 5'h10;
                8'h44:   v = 5'h12;
                8'h45:   v = 5'h14;
                8'h46:   v = 5'h15;
                8'h47:   v = 5'h17;
                8'h41:   v = 5'h19;
                8'h42:   v = 5'h1B;
                default: v = 5'h00;
            endcase
            return v;
        end
    endfunction

    function automatic logic [3:0] sat_channel(input logic [CNT_W-1:0] c);
        logic [CNT_W+3:0] ext;
        begin
            ext = {4'b0000, c};
            if (ext > (CNT_W + 4)'(15)) begin
                return 4'd15;
            end
            return ext[3:0];
        end
    endfunction

endpackage

`default_nettype wire

### design/note_track_text_parser_unit.sv
// Top level of the streaming note track text parser.
//
//  Channel  Signals                                   Direction  Transaction
//  char     char_code, char_valid, char_stall         in         one text byte
//  result   channel..end_of_track, result_valid,      out        one token result
//           result_stall
//
// One byte is taken every cycle while char_stall is low; a byte is parsed as it
// leaves the input register, and any result it closes goes to the result register.
// The rate is set by the single token state update and frequency lookup that
// sit between the input register and the result register.
// Reset clears all parser state and both valid flags; nothing else is needed.
// While result_stall holds a result, one more byte waits in the input register,
// after which char_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module note_track_text_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  char_code,
    input  wire logic        char_valid,
    output logic             char_stall,
    output logic [3:0]       channel,
    output logic             is_rest,
    output logic             has_decay,
    output logic [1:0]       waveform,
    output logic [6:0]       note_number,
    output logic [21:0]      frequency_q8,
    output logic [1:0]       status,
    output logic             line_end,
    output logic             end_of_track,
    output logic             result_valid,
    input  wire logic        result_stall
);
    import ntp_pkg::*;

    logic [7:0]       char_reg;
    logic             char_valid_reg;
    logic             advance;

    logic [2:0]       phase_reg,    phase_next;
    logic [3:0]       offset_reg,   offset_next;
    logic             sharp_reg,    sharp_next;
    logic [3:0]       octave_reg,   octave_next;
    logic [1:0]       wave_reg,     wave_next;
    logic             decay_reg,    decay_next;
    logic             bad_reg,      bad_next;
    logic [1:0]       endprog_reg,  endprog_next;
    logic             trail_reg,    trail_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic             sep_reg,      sep_next;
    logic             done_reg,     done_next;

    result_t          result_reg,   result_next;
    logic             result_valid_reg;
    logic             emit;

    result_t          tok;
    note_key_t        key;
    note_freq_t       nf;
    logic [4:0]       lcode;
    logic [7:0]       digit_val;
    logic             is_digit;
    logic             clear_tok;

    ntp_freq u_freq (
        .key (key),
        .res (nf)
    );

    assign key = {octave_reg, offset_reg, sharp_reg};

    assign advance    = char_valid_reg && (!result_valid_reg || !result_stall);
    assign char_stall = char_valid_reg && !advance;

    assign lcode     = letter_code(char_reg);
    assign digit_val = char_reg - CH_ZERO;
    assign is_digit  = (char_reg >= CH_ZERO) && (char_reg <= CH_EIGHT);

    // Result of closing the current token.
    always_comb
    begin
        tok = '0;
        tok.channel = sat_channel(count_reg);
        if (count_reg >= CNT_W'(MAX_CHANNELS))
        begin
            tok.status = ST_OVF;
        end
        else if (phase_reg == PH_EMPTY)
        begin
            tok.is_rest = 1'b1;
        end
        else if (phase_reg == PH_LONE_DASH)
        begin
            tok.is_rest   = 1'b1;
            tok.has_decay = 1'b1;
        end
        else if (bad_reg || phase_reg < PH_DIGIT || phase_reg == PH_JUNK)
        begin
            tok.status = ST_BAD;
        end
        else
        begin
            tok.note_number  = nf.note_number;
            tok.frequency_q8 = nf.frequency_q8;
            tok.waveform     = wave_reg;
            tok.has_decay    = decay_reg;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        sharp_next   = sharp_reg;
        octave_next  = octave_reg;
        wave_next    = wave_reg;
        decay_next   = decay_reg;
        bad_next     = bad_reg;
        endprog_next = endprog_reg;
        trail_next   = trail_reg;
        count_next   = count_reg;
        sep_next     = sep_reg;
        done_next    = done_reg;
        result_next  = tok;
        emit         = 1'b0;
        clear_tok    = 1'b0;

        if (!done_reg)
        begin
            if (char_reg == CH_LF)
            begin
                if (!sep_reg && phase_reg == PH_EMPTY)
                begin
                    emit = 1'b0;
                end
                else if (!sep_reg && endprog_reg == END_MATCHED)
                begin
                    result_next              = '0;
                    result_next.line_end     = 1'b1;
                    result_next.end_of_track = 1'b1;
                    done_next                = 1'b1;
                    emit                     = 1'b1;
                end
                else
                begin
                    result_next.line_end = 1'b1;
                    emit                 = 1'b1;
                end
                clear_tok  = 1'b1;
                count_next = '0;
                sep_next   = 1'b0;
            end
            else if (char_reg == CH_BAR)
            begin
                emit = 1'b1;
                if (count_reg < CNT_W'(MAX_CHANNELS))
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                sep_next  = 1'b1;
                clear_tok = 1'b1;
            end
            else if (char_reg == CH_SPACE || char_reg == CH_TAB || char_reg == CH_CR)
            begin
                if (phase_reg != PH_EMPTY)
                begin
                    trail_next = 1'b1;
                end
            end
            else if (trail_reg)
            begin
                // Content after inner whitespace spoils the token.
                endprog_next = 2'd0;
                bad_next     = 1'b1;
                phase_next   = PH_JUNK;
            end
            else
            begin
                if (phase_reg == PH_EMPTY && char_reg == CH_E)
                begin
                    endprog_next = 2'd1;
                end
                else if (endprog_reg == 2'd1 && char_reg == CH_N)
                begin
                    endprog_next = 2'd2;
                end
                else if (endprog_reg == 2'd2 && char_reg == CH_D)
                begin
                    endprog_next = END_MATCHED;
                end
                else
                begin
                    endprog_next = 2'd0;
                end

                unique case (phase_reg) inside
                    PH_EMPTY:
                    begin
                        if (lcode[4])
                        begin
                            offset_next = lcode[3:0];
                            phase_next  = PH_LETTER;
                        end
                        else if (char_reg == CH_DASH)
                        begin
                            phase_next = PH_LONE_DASH;
                        end
                        else
                        begin
                            bad_next   = 1'b1;
                            phase_next = PH_JUNK;
                        end
                    end
                    PH_LETTER, PH_SHARP:
                    begin
                        if (phase_reg == PH_LETTER && char_reg == CH_HASH)
                        begin
                            sharp_next = 1'b1;
                            phase_next = PH_SHARP;
                        end
                        else if (is_digit)
                        begin
                            octave_next = digit_val[3:0];
                            phase_next  = PH_DIGIT;
                        end
                        else
                        begin
                            bad_next   = 1'b1;
                            phase_next = PH_JUNK;
                        end
                    end
                    PH_DIGIT:
                    begin
                        if (char_reg == CH_P)
                        begin
                            wave_next  = WAVE_PULSE;
                            phase_next = PH_WAVE;
                        end
                        else if (char_reg == CH_BSL)
                        begin
                            wave_next  = WAVE_SAW;
                            phase_next = PH_WAVE;
                        end
                        else if (char_reg == CH_W)
                        begin
                            wave_next  = WAVE_TRI;
                            phase_next = PH_WAVE;
                        end
                        else if (char_reg == CH_DASH)
                        begin
                            decay_next = 1'b1;
                            phase_next = PH_DECAY;
                        end
                        else
                        begin
                            bad_next   = 1'b1;
                            phase_next = PH_JUNK;
                        end
                    end
                    PH_WAVE:
                    begin
                        if (char_reg == CH_DASH)
                        begin
                            decay_next = 1'b1;
                            phase_next = PH_DECAY;
                        end
                        else
                        begin
                            bad_next   = 1'b1;
                            phase_next = PH_JUNK;
                        end
                    end
                    default:
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_JUNK;
                    end
                endcase
            end

            if (clear_tok)
            begin
                phase_next   = PH_EMPTY;
                offset_next  = 4'd0;
                sharp_next   = 1'b0;
                octave_next  = 4'd0;
                wave_next    = WAVE_SINE;
                decay_next   = 1'b0;
                bad_next     = 1'b0;
                endprog_next = 2'd0;
                trail_next   = 1'b0;
            end
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else if (char_valid && !char_stall)
        begin
            char_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            char_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            char_reg <= char_code;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_EMPTY;
            offset_reg  <= 4'd0;
            sharp_reg   <= 1'b0;
            octave_reg  <= 4'd0;
            wave_reg    <= WAVE_SINE;
            decay_reg   <= 1'b0;
            bad_reg     <= 1'b0;
            endprog_reg <= 2'd0;
            trail_reg   <= 1'b0;
            count_reg   <= '0;
            sep_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            offset_reg  <= offset_next;
            sharp_reg   <= sharp_next;
            octave_reg  <= octave_next;
            wave_reg    <= wave_next;
            decay_reg   <= decay_next;
            bad_reg     <= bad_next;
            endprog_reg <= endprog_next;
            trail_reg   <= trail_next;
            count_reg   <= count_next;
            sep_reg     <= sep_next;
            done_reg    <= done_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= emit;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign channel      = result_reg.channel;
    assign is_rest      = result_reg.is_rest;
    assign has_decay    = result_reg.has_decay;
    assign waveform     = result_reg.waveform;
    assign note_number  = result_reg.note_number;
    assign frequency_q8 = result_reg.frequency_q8;
    assign status       = result_reg.status;
    assign line_end     = result_reg.line_end;
    assign end_of_track = result_reg.end_of_track;

`ifndef SYNTH
    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("track end flag cleared");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.end_of_track) |->
        (result_reg.line_end && result_reg.status == ST_OK && !result_reg.is_rest))
        else $error("malformed end of track result");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.status != ST_OK) |->
        (result_reg.note_number == 7'd0 && result_reg.frequency_q8 == 22'd0))
        else $error("error result carries a note");

    a_rest_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.is_rest) |->
        (result_reg.frequency_q8 == 22'd0 && result_reg.waveform == WAVE_SINE))
        else $error("rest carries a frequency");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CHANNELS))
        else $error("channel count out of range");
`endif

endmodule

`default_nettype wire

### design/ntp_freq.sv
// Note number and rounded equal-temperament frequency for one parsed note.
`timescale 1ns / 1ps
`default_nettype none

module ntp_freq (
    input  wire ntp_pkg::note_key_t key,
    output ntp_pkg::note_freq_t     res
);
    import ntp_pkg::*;

    logic [4:0]  k_sum;
    logic        wrap;
    logic [3:0]  k;
    logic [3:0]  lvl;
    logic [4:0]  shift;
    logic [29:0] base;
    logic [29:0] half;
    logic [29:0] sum;
    logic [29:0] shifted;
    logic [6:0]  note_num;

    // A sharp on B wraps into C of the next octave.
    assign k_sum   = {1'b0, key.offset} + {4'b0000, key.sharp};
    assign wrap    = (k_sum == 5'd12);
    assign k       = wrap ? 4'd0 : k_sum[3:0];
    assign lvl     = key.octave + {3'b000, wrap};
    assign shift   = 5'd16 - {1'b0, lvl};
    assign base    = freq_base(k);
    assign half    = 30'd1 << (shift - 5'd1);
    assign sum     = base + half;
    assign shifted = sum >> shift;

    assign note_num = {key.octave, 3'b000} + 7'({key.octave, 2'b00}) + 7'd12
                      + {2'b00, k_sum};
    assign res      = {note_num, shifted[21:0]};

endmodule

`default_nettype wire

### sim/ntp_checker.sv
// Checker for the note track text parser: predicts token results and compares them.
`timescale 1ns / 1ps

module ntp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_code,
    input  logic        char_valid,
    input  logic        char_stall,
    input  logic [3:0]  channel,
    input  logic        is_rest,
    input  logic        has_decay,
    input  logic [1:0]  waveform,
    input  logic [6:0]  note_number,
    input  logic [21:0] frequency_q8,
    input  logic [1:0]  status,
    input  logic        line_end,
    input  logic        end_of_track,
    input  logic        result_valid,
    input  logic        result_stall,
    output int          fail_count,
    output int          pending,
    output int          checked
);
    import ntp_pkg::*;

    // Octave-0 pitches of C..B in Hz, scaled by 2^24.
    localparam logic [29:0] OCT0_Q24 [12] = '{
        30'd274334289, 30'd290647054, 30'd307929828, 30'd326240288,
        30'd345639545, 30'd366192342, 30'd387967272, 30'd411037006,
        30'd435478539, 30'd461373440, 30'd488808132, 30'd517874176
    };

    // Token and line state of the parser as the text stream leaves it.
    logic [2:0] tok_phase;
    logic [3:0] semis;
    logic       sharp_on;
    logic [3:0] octave;
    logic [1:0] wave_sel;
    logic       decay_on;
    logic       tok_bad;
    logic [1:0] end_match;
    logic       trail_ws;
    int         chan_count;
    logic       bar_seen;
    logic       track_over;

    result_t    token_results_q[$];
    int         mismatches;
    int         matched;

    function automatic void add_result(input result_t r);
        token_results_q.insert(token_results_q.size(), r);
    endfunction

    function automatic void clear_token();
        tok_phase = PH_EMPTY;
        semis     = 4'd0;
        sharp_on  = 1'b0;
        octave    = 4'd0;
        wave_sel  = WAVE_SINE;
        decay_on  = 1'b0;
        tok_bad   = 1'b0;
        end_match = 2'd0;
        trail_ws  = 1'b0;
    endfunction

    function automatic void spoil();
        tok_bad   = 1'b1;
        tok_phase = PH_JUNK;
    endfunction

    function automatic int semitone(input logic [7:0] c);
        int semi;
        case (c)
            "C":     semi = 0;
            "D":     semi = 2;
            "E":     semi = 4;
            "F":     semi = 5;
            "G":     semi = 7;
            "A":     semi = 9;
            "B":     semi = 11;
            default: semi = -1;
        endcase
        return semi;
    endfunction

    // Rounded half up: the table entry shifted down to the note's octave.
    function automatic logic [21:0] pitch_q8(input logic [6:0] n);
        logic [63:0] base;
        int          k;
        int          sh;
        k    = int'(n) % 12;
        sh   = 16 - (int'(n) / 12 - 1);
        base = 64'(OCT0_Q24[k]);
        return 22'((base + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function automatic result_t close_token(input logic last);
        result_t    r;
        logic [6:0] n;
        r          = '0;
        r.channel  = (chan_count > 15) ? 4'd15 : 4'(chan_count);
        r.line_end = last;
        if (chan_count >= MAX_CHANNELS)
        begin
            r.status = ST_OVF;
        end
        else if (tok_phase == PH_EMPTY)
        begin
            r.is_rest = 1'b1;
        end
        else if (tok_phase == PH_LONE_DASH)
        begin
            r.is_rest   = 1'b1;
            r.has_decay = 1'b1;
        end
        else if (tok_bad || tok_phase < PH_DIGIT || tok_phase == PH_JUNK)
        begin
            r.status = ST_BAD;
        end
        else
        begin
            n              = 7'((int'(octave) + 1) * 12 + int'(semis) + int'(sharp_on));
            r.note_number  = n;
            r.frequency_q8 = pitch_q8(n);
            r.waveform     = wave_sel;
            r.has_decay    = decay_on;
        end
        return r;
    endfunction

    function automatic void take_char(input logic [7:0] c);
        int semi;
        if (trail_ws)
        begin
            // Anything after whitespace inside a token spoils it.
            end_match = 2'd0;
            spoil();
        end
        else
        begin
            if (tok_phase == PH_EMPTY && c == CH_E) end_match = 2'd1;
            else if (end_match == 2'd1 && c == CH_N) end_match = 2'd2;
            else if (end_match == 2'd2 && c == CH_D) end_match = END_MATCHED;
            else end_match = 2'd0;

            case (tok_phase) inside
                PH_EMPTY:
                begin
                    semi = semitone(c);
                    if (semi >= 0)
                    begin
                        semis     = 4'(semi);
                        tok_phase = PH_LETTER;
                    end
                    else if (c == CH_DASH)
                    begin
                        tok_phase = PH_LONE_DASH;
                    end
                    else
                    begin
                        spoil();
                    end
                end
                PH_LETTER, PH_SHARP:
                begin
                    if (tok_phase == PH_LETTER && c == CH_HASH)
                    begin
                        sharp_on  = 1'b1;
                        tok_phase = PH_SHARP;
                    end
                    else if (c >= CH_ZERO && c <= CH_EIGHT)
                    begin
                        octave    = 4'(c - CH_ZERO);
                        tok_phase = PH_DIGIT;
                    end
                    else
                    begin
                        spoil();
                    end
                end
                PH_DIGIT:
                begin
                    if (c == CH_P)
                    begin
                        wave_sel  = WAVE_PULSE;
                        tok_phase = PH_WAVE;
                    end
                    else if (c == CH_BSL)
                    begin
                        wave_sel  = WAVE_SAW;
                        tok_phase = PH_WAVE;
                    end
                    else if (c == CH_W)
                    begin
                        wave_sel  = WAVE_TRI;
                        tok_phase = PH_WAVE;
                    end
                    else if (c == CH_DASH)
                    begin
                        decay_on  = 1'b1;
                        tok_phase = PH_DECAY;
                    end
                    else
                    begin
                        spoil();
                    end
                end
                PH_WAVE:
                begin
                    if (c == CH_DASH)
                    begin
                        decay_on  = 1'b1;
                        tok_phase = PH_DECAY;
                    end
                    else
                    begin
                        spoil();
                    end
                end
                default: spoil();
            endcase
        end
    endfunction

    function automatic void absorb(input logic [7:0] c);
        result_t r;
        if (!track_over)
        begin
            if (c == CH_LF)
            begin
                // A blank line without separators closes nothing.
                if (bar_seen || tok_phase != PH_EMPTY)
                begin
                    if (!bar_seen && end_match == END_MATCHED)
                    begin
                        r              = '0;
                        r.line_end     = 1'b1;
                        r.end_of_track = 1'b1;
                        track_over     = 1'b1;
                        add_result(r);
                    end
                    else
                    begin
                        add_result(close_token(1'b1));
                    end
                end
                clear_token();
                chan_count = 0;
                bar_seen   = 1'b0;
            end
            else if (c == CH_BAR)
            begin
                add_result(close_token(1'b0));
                if (chan_count < MAX_CHANNELS) chan_count++;
                bar_seen = 1'b1;
                clear_token();
            end
            else if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
            begin
                if (tok_phase != PH_EMPTY) trail_ws = 1'b1;
            end
            else
            begin
                take_char(c);
            end
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            clear_token();
            chan_count = 0;
            bar_seen   = 1'b0;
            track_over = 1'b0;
            token_results_q.delete();
            mismatches = 0;
            matched    = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (token_results_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got channel %0d status %0d",
                             $time, channel, status);
                    mismatches++;
                end
                else
                begin
                    want = token_results_q.pop_front();
                    check_field("channel", 32'(want.channel), 32'(channel));
                    check_field("is_rest", 32'(want.is_rest), 32'(is_rest));
                    check_field("has_decay", 32'(want.has_decay), 32'(has_decay));
                    check_field("waveform", 32'(want.waveform), 32'(waveform));
                    check_field("note_number", 32'(want.note_number), 32'(note_number));
                    check_field("frequency_q8", 32'(want.frequency_q8),
                                32'(frequency_q8));
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("line_end", 32'(want.line_end), 32'(line_end));
                    check_field("end_of_track", 32'(want.end_of_track),
                                32'(end_of_track));
                    matched++;
                end
            end
            if (char_valid && !char_stall) absorb(char_code);
        end
        fail_count <= mismatches;
        pending    <= token_results_q.size();
        checked    <= matched;
    end

endmodule

### sim/testbench.sv
// Top of the note track text parser testbench: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module testbench;
    import ntp_pkg::*;

    localparam int         CLK_PERIOD     = 8;
    localparam int         RANDOM_CHARS   = 1320;
    localparam int         SQUEEZE_AT     = 450;
    localparam int         DRAIN_AT       = 900;
    localparam int         SQUEEZE_CYCLES = 300;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam logic [7:0] CH_A           = 8'h41;
    localparam logic [7:0] CH_H           = 8'h48;

    logic        clk = 1'b0;
    logic        rst_n;
    logic [7:0]  char_code;
    logic        char_valid;
    logic        char_stall;
    logic [3:0]  channel;
    logic        is_rest;
    logic        has_decay;
    logic [1:0]  waveform;
    logic [6:0]  note_number;
    logic [21:0] frequency_q8;
    logic [1:0]  status;
    logic        line_end;
    logic        end_of_track;
    logic        result_valid;
    logic        result_stall;

    int          fail_count;
    int          pending;
    int          checked;
    int          chars_sent;
    int          burst_left;
    int          quiet_cycles;
    logic        squeeze_req;
    logic        squeeze_done;
    logic [7:0]  line_buf[$];

    always #(CLK_PERIOD / 2) clk = ~clk;

    note_track_text_parser_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_code    (char_code),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .channel      (channel),
        .is_rest      (is_rest),
        .has_decay    (has_decay),
        .waveform     (waveform),
        .note_number  (note_number),
        .frequency_q8 (frequency_q8),
        .status       (status),
        .line_end     (line_end),
        .end_of_track (end_of_track),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    ntp_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_code    (char_code),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .channel      (channel),
        .is_rest      (is_rest),
        .has_decay    (has_decay),
        .waveform     (waveform),
        .note_number  (note_number),
        .frequency_q8 (frequency_q8),
        .status       (status),
        .line_end     (line_end),
        .end_of_track (end_of_track),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    function automatic bit is_ws(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endfunction

    function automatic void pad();
        int n;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            case ($urandom_range(0, 2))
                0:       add_byte(CH_SPACE);
                1:       add_byte(CH_TAB);
                default: add_byte(CH_CR);
            endcase
        end
    endfunction

    function automatic logic [7:0] any_letter();
        return CH_A + 8'($urandom_range(0, 6));
    endfunction

    function automatic logic [7:0] any_digit();
        return CH_ZERO + 8'($urandom_range(0, 8));
    endfunction

    function automatic void push_token(input bit multi);
        int         pick;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) pad();
        if (pick < 62)
        begin
            add_byte(any_letter());
            if ($urandom_range(0, 2) == 0) add_byte(CH_HASH);
            add_byte(any_digit());
            case ($urandom_range(0, 4))
                0:       add_byte(CH_P);
                1:       add_byte(CH_BSL);
                2:       add_byte(CH_W);
                default: ;
            endcase
            if ($urandom_range(0, 2) == 0) add_byte(CH_DASH);
        end
        else if (pick < 72)
        begin
            // Empty token: a rest.
        end
        else if (pick < 78)
        begin
            add_byte(CH_DASH);
        end
        else if (pick < 90)
        begin
            case ($urandom_range(0, 7))
                0: add_byte(any_letter());
                1:
                begin
                    add_byte(any_letter());
                    add_byte(CH_HASH);
                end
                2:
                begin
                    add_byte(any_letter());
                    add_byte(CH_ZERO + 8'd9);
                end
                3:
                begin
                    add_byte(any_letter());
                    add_byte(CH_SPACE);
                    add_byte(any_digit());
                end
                4:
                begin
                    add_byte(any_letter());
                    add_byte(any_digit());
                    add_byte(CH_HASH);
                end
                5:
                begin
                    add_byte(CH_DASH);
                    add_byte(CH_DASH);
                end
                6:
                begin
                    add_byte(any_letter());
                    add_byte(any_digit());
                    add_byte(CH_DASH);
                    add_byte(CH_P);
                end
                default:
                begin
                    if (multi)
                    begin
                        add_byte(CH_E);
                        add_byte(CH_N);
                        add_byte(CH_D);
                    end
                    else
                    begin
                        add_byte(CH_H);
                        add_byte(any_digit());
                    end
                end
            endcase
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_BAR);
                add_byte(b);
            end
        end
        if ($urandom_range(0, 3) == 0) pad();
    endfunction

    // A separator-free line that trims to END would stop the track early.
    function automatic bit trims_to_end();
        int lo;
        int hi;
        lo = 0;
        hi = line_buf.size() - 1;
        while (lo <= hi && is_ws(line_buf[lo])) lo++;
        while (hi >= lo && is_ws(line_buf[hi])) hi--;
        return (hi - lo == 2) && line_buf[lo] == CH_E && line_buf[lo + 1] == CH_N
               && line_buf[hi] == CH_D;
    endfunction

    function automatic void build_line();
        int pick;
        int ntok;
        line_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            if ($urandom_range(0, 1) == 0) pad();
        end
        else
        begin
            ntok = (pick < 10) ? $urandom_range(15, 20) : $urandom_range(1, 6);
            for (int i = 0; i < ntok; i++)
            begin
                if (i > 0) add_byte(CH_BAR);
                push_token(ntok > 1);
            end
            if (ntok == 1 && trims_to_end()) add_byte(CH_W);
        end
        add_byte(CH_LF);
    endfunction

    task automatic idle(input int n);
        if (n > 0)
        begin
            char_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic offer(input logic [7:0] b);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 30);
            // No gaps while the receiver is holding off, so the block fills up.
            if (!(squeeze_req && !squeeze_done))
                idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25));
        end
        burst_left--;
        char_code  <= b;
        char_valid <= 1'b1;
        @(posedge clk);
        while (char_stall) @(posedge clk);
        chars_sent++;
    endtask

    task automatic wait_drain();
        char_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin : result_side
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        mode         = 0;
        mode_left    = 0;
        hold_left    = 0;
        tick         = 0;
        squeeze_done = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (squeeze_req && !squeeze_done && hold_left == 0) hold_left = SQUEEZE_CYCLES;
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
                if (hold_left == 0) squeeze_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 99) < 30);
                    2:       result_stall <= ($urandom_range(0, 99) < 75);
                    default: result_stall <= (tick % 7 < 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (char_valid && !char_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, pending);
            $display("testbench: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        string intro;
        string outro;
        bit    paused;
        intro        = "C0|B#8W-|-||\tA4P |END|G#3\\\n \015\n";
        outro        = " \tEND \015\nC4|D4\n";
        paused       = 1'b0;
        rst_n        = 1'b0;
        char_valid   = 1'b0;
        char_code    = 8'd0;
        squeeze_req  = 1'b0;
        chars_sent   = 0;
        burst_left   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < intro.len(); i++) offer(intro[i]);

        while (chars_sent < RANDOM_CHARS)
        begin
            if (!squeeze_req && chars_sent >= SQUEEZE_AT) squeeze_req = 1'b1;
            if (!paused && chars_sent >= DRAIN_AT)
            begin
                wait_drain();
                paused = 1'b1;
            end
            build_line();
            foreach (line_buf[i]) offer(line_buf[i]);
        end

        // The END line stops the track; the bytes after it must be ignored.
        for (int i = 0; i < outro.len(); i++) offer(outro[i]);

        wait_drain();
        repeat (40) @(posedge clk);

        $display("summary: %0d characters sent, %0d token results checked", chars_sent, checked);
        $display("summary: notes, rests, malformed and overflowing tokens, one long hold, END");
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
